### hdl/srl_pkg.sv
package srl_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_ADDR_WIDTH  = 32;

    localparam int MODE_W      = 1;
    localparam int SLOT_W      = 10;
    localparam int FIELD_W     = 32;
    localparam int CFG_COUNT_W = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CFG_COUNT_W;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 144;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 1'b0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THUMB_BIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ENTRY,
        ST_GAP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] normalized_address;
        logic [SLOT_W-1:0]  symbol_index;
        logic [FIELD_W-1:0] name_ptr;
        logic [FIELD_W-1:0] offset_in_function;
        logic [FIELD_W-1:0] function_size;
    } t_result;

endpackage

### hdl/srl_ram.sv
module srl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/srl_engine.sv
module srl_engine #(
    parameter int TABLE_DEPTH = srl_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = srl_pkg::DEF_ADDR_WIDTH
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [ADDR_WIDTH-1:0]                             i_addr,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]                  i_count,
    output logic                                              o_idle,
    output logic                                              o_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]                    o_rd_addr,
    input  logic [2*ADDR_WIDTH+srl_pkg::FIELD_W-1:0]          i_rd_data,
    output logic                                              o_done,
    output srl_pkg::t_result                                  o_res,
    input  logic                                              i_take
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 2 * ADDR_WIDTH + srl_pkg::FIELD_W;

    srl_pkg::t_state r_state, n_state;

    logic [ADDR_WIDTH-1:0]       r_addr, n_addr;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [CNT_W-1:0]            r_lo, n_lo;
    logic [CNT_W-1:0]            r_hi, n_hi;
    logic [CNT_W-1:0]            r_mid, n_mid;
    logic [ADDR_WIDTH-1:0]       r_base, n_base;
    logic [ADDR_WIDTH-1:0]       r_size, n_size;
    logic [srl_pkg::FIELD_W-1:0] r_name, n_name;

    logic [ADDR_WIDTH-1:0]       rd_start, rd_len;
    logic [srl_pkg::FIELD_W-1:0] rd_name;
    logic                        le;
    logic [CNT_W-1:0]            srch_lo, srch_hi, srch_mid, hit_idx;
    logic                        srch_more, need_gap;
    logic [ADDR_WIDTH-1:0]       off;
    logic                        found;

    assign rd_start = i_rd_data[ADDR_WIDTH-1:0];
    assign rd_len   = i_rd_data[2*ADDR_WIDTH-1:ADDR_WIDTH];
    assign rd_name  = i_rd_data[ENT_W-1:2*ADDR_WIDTH];

    assign le        = (rd_start <= r_addr);
    assign srch_lo   = le ? (r_mid + CNT_W'(1)) : r_lo;
    assign srch_hi   = le ? r_hi : r_mid;
    assign srch_mid  = srch_lo + ((srch_hi - srch_lo) >> 1);
    assign srch_more = (srch_lo < srch_hi);
    assign need_gap  = (rd_len == '0) && (r_lo < r_count);

    assign hit_idx = r_lo - CNT_W'(1);
    assign off     = r_addr - r_base;
    assign found   = (r_lo != '0) && (r_size != '0) && (off < r_size);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srl_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_count != '0) ? srl_pkg::ST_SEARCH : srl_pkg::ST_FINISH;
                end
            end
            srl_pkg::ST_SEARCH: begin
                priority if (srch_more) begin
                    n_state = srl_pkg::ST_SEARCH;
                end else if (srch_lo == '0) begin
                    n_state = srl_pkg::ST_FINISH;
                end else begin
                    n_state = srl_pkg::ST_ENTRY;
                end
            end
            srl_pkg::ST_ENTRY: begin
                n_state = need_gap ? srl_pkg::ST_GAP : srl_pkg::ST_FINISH;
            end
            srl_pkg::ST_GAP: begin
                n_state = srl_pkg::ST_FINISH;
            end
            srl_pkg::ST_FINISH: begin
                if (i_take) begin
                    n_state = srl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_addr    = r_addr;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_base    = r_base;
        n_size    = r_size;
        n_name    = r_name;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_idle    = 1'b0;
        o_done    = 1'b0;
        unique case (r_state)
            srl_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_addr    = i_addr;
                    n_count   = i_count;
                    n_lo      = '0;
                    n_hi      = i_count;
                    n_mid     = i_count >> 1;
                    o_rd_en   = (i_count != '0);
                    o_rd_addr = IDX_W'(i_count >> 1);
                end
            end
            srl_pkg::ST_SEARCH: begin
                n_lo  = srch_lo;
                n_hi  = srch_hi;
                n_mid = srch_mid;
                if (srch_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = IDX_W'(srch_mid);
                end else if (srch_lo != '0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = IDX_W'(srch_lo - CNT_W'(1));
                end
            end
            srl_pkg::ST_ENTRY: begin
                n_base = rd_start;
                n_size = rd_len;
                n_name = rd_name;
                if (need_gap) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = IDX_W'(r_lo);
                end
            end
            srl_pkg::ST_GAP: begin
                n_size = rd_start - r_base;
            end
            srl_pkg::ST_FINISH: begin
                o_done = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res.found              = found;
        o_res.normalized_address = srl_pkg::FIELD_W'(r_addr);
        o_res.symbol_index       = found ? srl_pkg::SLOT_W'(hit_idx) : '0;
        o_res.name_ptr           = found ? r_name : '0;
        o_res.offset_in_function = found ? srl_pkg::FIELD_W'(off) : '0;
        o_res.function_size      = found ? srl_pkg::FIELD_W'(r_size) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_count <= n_count;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_base  <= n_base;
        r_size  <= n_size;
        r_name  <= n_name;
    end

`ifndef NO_ASSERTIONS
    a_search_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srl_pkg::ST_SEARCH) |-> (r_lo < r_hi))
        else $error("search window empty while searching");

    a_hi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srl_pkg::ST_SEARCH) |-> (r_hi <= r_count))
        else $error("search upper bound beyond count");

    a_entry_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srl_pkg::ST_ENTRY) |-> (r_lo != '0))
        else $error("entry fetch without a candidate");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idle && i_start) |=> (r_state != srl_pkg::ST_IDLE))
        else $error("lookup request dropped");
`endif

endmodule

### hdl/symbol_range_lookup_core.sv
// Sorted symbol table with address-to-symbol lookup. Load requests (tuser 0)
// write one record (start, size, name pointer) per cycle while no lookup is
// in progress. Lookup requests (tuser 1) run an upper-bound binary search
// over the first symbol_count records held in a single-port table RAM, one
// RAM read per halving step. A lookup then fetches the entry record, unless
// the table is empty or the address lies below the first record, and reads
// the next record's start when a zero size must be resolved from it. The
// result is held in an output register, so the next request is taken while
// it waits. The table is not cleared at reset; records must be loaded before
// they are searched. Configuration must be written only while no lookup is
// in flight; the block itself does not enforce this.
module symbol_range_lookup_core #(
    parameter int TABLE_DEPTH = srl_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = srl_pkg::DEF_ADDR_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // entry_index, entry_start, entry_length, entry_name_ptr, query_address
    input  logic [srl_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // mode
    input  logic [srl_pkg::MODE_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // normalized_address, symbol_index, name_ptr, offset_in_function,
    // function_size
    output logic [srl_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // found
    output logic                               o_m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [srl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 2 * ADDR_WIDTH + srl_pkg::FIELD_W;
    localparam int FW    = srl_pkg::FIELD_W;
    localparam int SW    = srl_pkg::SLOT_W;

    logic [srl_pkg::CFG_COUNT_W-1:0] r_symbol_count;
    logic                            r_clear_thumb_bit;
    logic                            r_out_valid;
    srl_pkg::t_result                r_out;

    logic [SW-1:0]         in_slot;
    logic [FW-1:0]         in_start, in_length, in_name, in_query;
    logic                  in_acc, is_lookup, load_we;
    logic [ADDR_WIDTH-1:0] q_addr;
    logic [CNT_W-1:0]      count;

    logic                  eng_idle, eng_rd_en, eng_done, take;
    logic [IDX_W-1:0]      eng_rd_addr, ram_addr;
    logic [ENT_W-1:0]      ram_wdata, ram_rdata;
    srl_pkg::t_result      eng_res;

    assign in_slot   = i_s_axis_tdata[SW-1:0];
    assign in_start  = i_s_axis_tdata[SW+FW-1:SW];
    assign in_length = i_s_axis_tdata[SW+2*FW-1:SW+FW];
    assign in_name   = i_s_axis_tdata[SW+3*FW-1:SW+2*FW];
    assign in_query  = i_s_axis_tdata[SW+4*FW-1:SW+3*FW];

    assign o_s_axis_tready = eng_idle;
    assign in_acc          = i_s_axis_tvalid && eng_idle;
    assign is_lookup       = (i_s_axis_tuser == srl_pkg::MODE_LOOKUP);
    assign load_we         = in_acc && (i_s_axis_tuser == srl_pkg::MODE_LOAD)
                             && (32'(in_slot) < 32'(TABLE_DEPTH));

    always_comb begin
        q_addr = ADDR_WIDTH'(in_query);
        if (r_clear_thumb_bit) begin
            q_addr[0] = 1'b0;
        end
        if (32'(r_symbol_count) > 32'(TABLE_DEPTH)) begin
            count = CNT_W'(TABLE_DEPTH);
        end else begin
            count = CNT_W'(r_symbol_count);
        end
    end

    assign ram_wdata = {in_name, ADDR_WIDTH'(in_length), ADDR_WIDTH'(in_start)};
    assign ram_addr  = load_we ? IDX_W'(in_slot) : eng_rd_addr;

    srl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_re    (eng_rd_en),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    srl_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc && is_lookup),
        .i_addr    (q_addr),
        .i_count   (count),
        .o_idle    (eng_idle),
        .o_rd_en   (eng_rd_en),
        .o_rd_addr (eng_rd_addr),
        .i_rd_data (ram_rdata),
        .o_done    (eng_done),
        .o_res     (eng_res),
        .i_take    (take)
    );

    assign take = eng_done && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count    <= '0;
            r_clear_thumb_bit <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    srl_pkg::REG_SYMBOL_COUNT:    r_symbol_count    <= i_cfg_data;
                    srl_pkg::REG_CLEAR_THUMB_BIT: r_clear_thumb_bit <= i_cfg_data[0];
                    default:                      r_clear_thumb_bit <= r_clear_thumb_bit;
                endcase
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= eng_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.found;
    assign o_m_axis_tdata  = {6'b0, r_out.function_size, r_out.offset_in_function,
                              r_out.name_ptr, r_out.symbol_index,
                              r_out.normalized_address};

endmodule
